>>> rtl/start_stop_elapsed_timer_display_macros.svh
// Assertion helpers for the elapsed timer display.
`ifndef START_STOP_ELAPSED_TIMER_DISPLAY_MACROS_SVH
`define START_STOP_ELAPSED_TIMER_DISPLAY_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SSET_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SSET_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/sset_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sset_pkg;

    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;
    localparam logic [1:0] MODE_HALT  = 2'd2;

    localparam logic [6:0] LIMIT_MIN = 7'd1;
    localparam logic [6:0] LIMIT_MAX = 7'd99;
    localparam logic [6:0] BCD_59    = 7'h59;

    // one display digit is held as its 4-bit value; the character adds ASCII '0'
    typedef struct packed {
        logic [3:0] hour_hi;
        logic [3:0] hour_lo;
        logic [3:0] min_hi;
        logic [3:0] min_lo;
        logic [3:0] sec_hi;
        logic [3:0] sec_lo;
    } digits_t;

    typedef struct packed {
        logic       start_key;
        logic       stop_key;
        logic [6:0] clock_seconds;
        logic [6:0] clock_minutes;
        logic [5:0] clock_hours;
        logic [2:0] clock_day;
    } sample_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       clock_restart;
        logic       mode_store;
        digits_t    digits;
    } tick_t;

    localparam digits_t DIGITS_ZERO = '0;

    // ASCII '0' is 0x30, so the low six bits of the character are 2'b11 and the digit
    function automatic logic [5:0] to_char(input logic [3:0] d);
        return {2'b11, d};
    endfunction

endpackage

`default_nettype wire

>>> rtl/start_stop_elapsed_timer_display.sv
`timescale 1ns / 1ps
`default_nettype none
// Start/stop elapsed timer display.
// Input stream (s_axis): one request per task tick, carrying the key states and
// one BCD sample of the real-time clock. Output stream (m_axis): one result per
// request with the mode, the clock restart and mode store pulses and the six
// display characters (low six bits of the ASCII digit).
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per clock while the receiver keeps up; the mode/digit
// update loops via the tick logic into mode_reg/digits_reg, setting that figure.
// The output register takes a new request while the held result is being taken,
// so s_axis_tready = !m_axis_tvalid || m_axis_tready. When the receiver stalls,
// the result holds and the input side stops after one waiting result.
// cfg_we/cfg_data write hour_limit (auto-halt hour); the user must write only while the block is idle (unenforced).
// Reset: mode is reset, all digits read '0', hour_limit is 99, output empty.
module start_stop_elapsed_timer_display (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_data,       // hour_limit
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] start_key, [1] stop_key, [8:2] clock_seconds, [15:9] clock_minutes,
    // [21:16] clock_hours, [24:22] clock_day, [31:25] zero
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] mode, [2] clock_restart, [3] mode_store, [9:4] sec_low_char,
    // [15:10] sec_high_char, [21:16] min_low_char, [27:22] min_high_char,
    // [33:28] hour_low_char, [39:34] hour_high_char
    output logic [39:0]      m_axis_tdata
);
    import sset_pkg::*;

    logic [6:0]  limit_reg;
    logic [1:0]  mode_reg;
    digits_t     digits_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [39:0] out_data_reg;
    sample_t     sample;
    tick_t       tick;
    logic        in_accept;

    assign sample.start_key     = s_axis_tdata[0];
    assign sample.stop_key      = s_axis_tdata[1];
    assign sample.clock_seconds = s_axis_tdata[8:2];
    assign sample.clock_minutes = s_axis_tdata[15:9];
    assign sample.clock_hours   = s_axis_tdata[21:16];
    assign sample.clock_day     = s_axis_tdata[24:22];

    sset_tick_logic u_tick (
        .mode       (mode_reg),
        .digits     (digits_reg),
        .sample     (sample),
        .hour_limit (limit_reg),
        .tick       (tick)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_MAX;
            mode_reg      <= MODE_RESET;
            digits_reg    <= DIGITS_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (in_accept)
            begin
                mode_reg   <= tick.mode;
                digits_reg <= tick.digits;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= {to_char(tick.digits.hour_hi), to_char(tick.digits.hour_lo),
                             to_char(tick.digits.min_hi),  to_char(tick.digits.min_lo),
                             to_char(tick.digits.sec_hi),  to_char(tick.digits.sec_lo),
                             tick.mode_store, tick.clock_restart, tick.mode};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`include "start_stop_elapsed_timer_display_macros.svh"

    `SSET_ASSERT_IMP(a_restart_clears, m_axis_tvalid && m_axis_tdata[2], (m_axis_tdata[1:0] == MODE_COUNT) && m_axis_tdata[3] && (m_axis_tdata[39:4] == 36'hC30C30C30), "restart without count mode or cleared digits")
    `SSET_ASSERT_NXT(a_store_on_change, in_accept, m_axis_tdata[3] == (m_axis_tdata[1:0] != $past(mode_reg)), "mode_store does not match mode change")
    `SSET_ASSERT_NXT(a_state_matches_out, in_accept, (m_axis_tdata[1:0] == mode_reg) && m_axis_tvalid, "result mode differs from held mode")
    `SSET_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "not ready with empty output")

endmodule

`default_nettype wire

>>> rtl/sset_tick_logic.sv
`timescale 1ns / 1ps
`default_nettype none

module sset_tick_logic (
    input  wire logic [1:0]       mode,
    input  wire sset_pkg::digits_t digits,
    input  wire sset_pkg::sample_t sample,
    input  wire logic [6:0]       hour_limit,
    output sset_pkg::tick_t       tick
);
    import sset_pkg::*;

    logic [6:0]  lim;
    logic [2:0]  days;
    logic [7:0]  day_hours;
    logic [7:0]  tens_hours;
    logic [7:0]  hours_raw;
    logic [6:0]  hours;
    logic [14:0] recip;
    logic [3:0]  hours_tens;
    logic [6:0]  tens_x10;
    logic [6:0]  hours_units;
    logic        auto_halt;
    digits_t     upd;

    always_comb
    begin
        if (hour_limit < LIMIT_MIN)
        begin
            lim = LIMIT_MIN;
        end
        else if (hour_limit > LIMIT_MAX)
        begin
            lim = LIMIT_MAX;
        end
        else
        begin
            lim = hour_limit;
        end
    end

    // day zero counts as day one
    assign days       = (sample.clock_day == 3'd0) ? 3'd0 : sample.clock_day - 3'd1;
    assign day_hours  = {1'b0, days, 4'b0} + {2'b0, days, 3'b0};
    assign tens_hours = {3'b0, sample.clock_hours[5:4], 3'b0}
                      + {5'b0, sample.clock_hours[5:4], 1'b0};
    assign hours_raw  = day_hours + tens_hours + {4'b0, sample.clock_hours[3:0]};
    assign hours      = (hours_raw > {1'b0, lim}) ? lim : hours_raw[6:0];

    // divide by ten via reciprocal 205/2048, exact below 1029
    assign recip       = {8'b0, hours} * 15'd205;
    assign hours_tens  = recip[14:11];
    assign tens_x10    = {hours_tens, 3'b0} + {2'b0, hours_tens, 1'b0};
    assign hours_units = hours - tens_x10;

    assign upd.sec_lo  = sample.clock_seconds[3:0];
    assign upd.sec_hi  = {1'b0, sample.clock_seconds[6:4]};
    assign upd.min_lo  = sample.clock_minutes[3:0];
    assign upd.min_hi  = {1'b0, sample.clock_minutes[6:4]};
    assign upd.hour_lo = hours_units[3:0];
    assign upd.hour_hi = hours_tens;

    assign auto_halt = (hours == lim) && (sample.clock_minutes == BCD_59)
                    && (sample.clock_seconds == BCD_59);

    always_comb
    begin
        tick.mode          = mode;
        tick.clock_restart = 1'b0;
        tick.mode_store    = 1'b0;
        tick.digits        = digits;
        unique case (mode)
            MODE_RESET, MODE_HALT:
            begin
                if (sample.start_key)
                begin
                    tick.mode          = MODE_COUNT;
                    tick.clock_restart = 1'b1;
                    tick.mode_store    = 1'b1;
                    tick.digits        = DIGITS_ZERO;
                end
            end
            MODE_COUNT:
            begin
                // stop wins over start and freezes the digits
                if (sample.stop_key)
                begin
                    tick.mode       = MODE_HALT;
                    tick.mode_store = 1'b1;
                end
                else
                begin
                    tick.digits = upd;
                    if (auto_halt)
                    begin
                        tick.mode       = MODE_HALT;
                        tick.mode_store = 1'b1;
                    end
                end
            end
            default:
            begin
                tick.mode = mode;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> bench/start_stop_elapsed_timer_display_test.sv
`timescale 1ns / 1ps

module start_stop_elapsed_timer_display_test;

    import sset_pkg::*;

    localparam int ASCII_ZERO  = 48;
    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 19;

    // request layout, lowest bits last
    typedef struct packed {
        logic [6:0] pad;
        logic [2:0] clock_day;
        logic [5:0] clock_hours;
        logic [6:0] clock_minutes;
        logic [6:0] clock_seconds;
        logic       stop_key;
        logic       start_key;
    } tick_req_t;

    typedef struct packed {
        logic [5:0] hour_high_char;
        logic [5:0] hour_low_char;
        logic [5:0] min_high_char;
        logic [5:0] min_low_char;
        logic [5:0] sec_high_char;
        logic [5:0] sec_low_char;
        logic       mode_store;
        logic       clock_restart;
        logic [1:0] mode;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    start_stop_elapsed_timer_display u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    tick_req_t     tick_requests [$];
    timer_result_t expected_ticks [$];

    // predictor state
    logic [1:0] timer_mode = MODE_RESET;
    logic [5:0] shown_char [6] = '{default: 6'd48};
    logic [6:0] hour_limit_q = 7'd99;

    int cycle_count     = 0;
    int error_count     = 0;
    int requests_taken  = 0;
    int results_checked = 0;
    int restart_count   = 0;
    int auto_halt_count = 0;
    int limit_writes    = 0;

    function automatic int effective_limit(input logic [6:0] lim);
        if (lim < LIMIT_MIN)
            return int'(LIMIT_MIN);
        if (lim > LIMIT_MAX)
            return int'(LIMIT_MAX);
        return int'(lim);
    endfunction

    function automatic timer_result_t advance_timer(input tick_req_t t);
        timer_result_t r;
        int lim;
        int days;
        int hours;
        r = '0;
        case (timer_mode)
            MODE_RESET, MODE_HALT:
            begin
                if (t.start_key)
                begin
                    foreach (shown_char[i])
                        shown_char[i] = 6'(ASCII_ZERO);
                    r.clock_restart = 1'b1;
                    r.mode_store = 1'b1;
                    timer_mode = MODE_COUNT;
                    restart_count++;
                end
            end
            MODE_COUNT:
            begin
                if (t.stop_key)
                begin
                    timer_mode = MODE_HALT;
                    r.mode_store = 1'b1;
                end
                else
                begin
                    lim = effective_limit(hour_limit_q);
                    days = (t.clock_day > 0) ? int'(t.clock_day) - 1 : 0;
                    hours = days * 24 + int'(t.clock_hours[5:4]) * 10
                            + int'(t.clock_hours[3:0]);
                    if (hours > lim)
                        hours = lim;
                    // non-BCD nibbles pass straight through as binary
                    shown_char[0] = 6'(ASCII_ZERO + int'(t.clock_seconds[3:0]));
                    shown_char[1] = 6'(ASCII_ZERO + int'(t.clock_seconds[6:4]));
                    shown_char[2] = 6'(ASCII_ZERO + int'(t.clock_minutes[3:0]));
                    shown_char[3] = 6'(ASCII_ZERO + int'(t.clock_minutes[6:4]));
                    shown_char[4] = 6'(ASCII_ZERO + hours % 10);
                    shown_char[5] = 6'(ASCII_ZERO + hours / 10);
                    if (hours == lim && t.clock_minutes == BCD_59
                        && t.clock_seconds == BCD_59)
                    begin
                        timer_mode = MODE_HALT;
                        r.mode_store = 1'b1;
                        auto_halt_count++;
                    end
                end
            end
            default: ;
        endcase
        r.mode = timer_mode;
        r.sec_low_char = shown_char[0];
        r.sec_high_char = shown_char[1];
        r.min_low_char = shown_char[2];
        r.min_high_char = shown_char[3];
        r.hour_low_char = shown_char[4];
        r.hour_high_char = shown_char[5];
        return r;
    endfunction

    // idle stretches off for the tail end of every cycle_count % 1500 window
    function automatic bit take_gap();
        return (cycle_count % 1500 < 1100) && ($urandom_range(99) < IDLE_PCT);
    endfunction

    always @(posedge clk)
    begin : request_drive
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_ticks.push_back(advance_timer(s_axis_tdata));
            requests_taken++;
        end
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (tick_requests.size() != 0 && !take_gap())
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= tick_requests.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        timer_result_t got;
        timer_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_ticks.size() == 0)
            begin
                $error("result with no request outstanding: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                check_field("mode", want.mode, got.mode);
                check_field("clock_restart", want.clock_restart, got.clock_restart);
                check_field("mode_store", want.mode_store, got.mode_store);
                check_field("sec_low_char", want.sec_low_char, got.sec_low_char);
                check_field("sec_high_char", want.sec_high_char, got.sec_high_char);
                check_field("min_low_char", want.min_low_char, got.min_low_char);
                check_field("min_high_char", want.min_high_char, got.min_high_char);
                check_field("hour_low_char", want.hour_low_char, got.hour_low_char);
                check_field("hour_high_char", want.hour_high_char, got.hour_high_char);
                results_checked++;
            end
        end
        m_axis_tready <= rst_n && !take_gap();
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_ticks.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [6:0] to_bcd(input int v);
        logic [6:0] b;
        b = 7'(((v / 10) << 4) | (v % 10));
        return b;
    endfunction

    function automatic tick_req_t tick(input bit start, input bit stop,
                                       input logic [6:0] sec, input logic [6:0] min,
                                       input logic [5:0] hr, input logic [2:0] day);
        tick_req_t t;
        t = '0;
        t.start_key = start;
        t.stop_key = stop;
        t.clock_seconds = sec;
        t.clock_minutes = min;
        t.clock_hours = hr;
        t.clock_day = day;
        return t;
    endfunction

    // plausible clock sample
    function automatic tick_req_t rand_sample(input bit start, input bit stop);
        return tick(start, stop, to_bcd($urandom_range(59)), to_bcd($urandom_range(59)),
                    6'(to_bcd($urandom_range(23))), 3'($urandom_range(7, 1)));
    endfunction

    // start, a run of counting ticks, then auto-halt, stop or nothing
    task automatic queue_session(inout int n);
        int ticks;
        int lim;
        int target;
        tick_req_t t;
        tick_requests.push_back(rand_sample(1'b1, 1'($urandom_range(1))));
        n++;
        ticks = $urandom_range(12, 1);
        repeat (ticks)
        begin
            tick_requests.push_back(rand_sample($urandom_range(9) == 0, 1'b0));
            n++;
        end
        case ($urandom_range(3))
            0:
            begin
                lim = effective_limit(hour_limit_q);
                target = $urandom_range((lim + 6 > 167) ? 167 : lim + 6, lim);
                t = tick($urandom_range(1) == 0, 1'b0, BCD_59, BCD_59,
                         6'(to_bcd(target % 24)), 3'(target / 24 + 1));
                tick_requests.push_back(t);
                n++;
            end
            1, 2:
            begin
                tick_requests.push_back(rand_sample(1'($urandom_range(1)), 1'b1));
                n++;
            end
            default: ;
        endcase
    endtask

    task automatic queue_random(input int count);
        int n;
        tick_req_t t;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) < 7)
                queue_session(n);
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    t = $urandom;
                    t.pad = '0;
                    tick_requests.push_back(t);
                    n++;
                end
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_requests.size() != 0 || s_axis_tvalid || expected_ticks.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_hour_limit(input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value[6:0];
        hour_limit_q = value[6:0];
        limit_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int limit_plan [5];
        limit_plan = '{1, 0, 127, 99, 0};
        limit_plan[4] = $urandom_range(98, 2);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed ticks at the reset limit of 99
        tick_requests.push_back(tick(1'b0, 1'b1, 7'h12, 7'h34, 6'h05, 3'd1));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h45, 7'h21, 6'h13, 3'd3));
        tick_requests.push_back(tick(1'b1, 1'b1, 7'h07, 7'h08, 6'h09, 3'd2));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h00, 7'h00, 6'h00, 3'd0));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h7F, 7'h7F, 6'h3F, 3'd7));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h4F, 7'h5E, 6'h1C, 3'd1));
        tick_requests.push_back(tick(1'b1, 1'b0, 7'h10, 7'h20, 6'h12, 3'd2));
        tick_requests.push_back(tick(1'b1, 1'b1, 7'h33, 7'h44, 6'h11, 3'd4));
        tick_requests.push_back(tick(1'b0, 1'b1, 7'h01, 7'h02, 6'h03, 3'd1));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h59, 7'h59, 6'h23, 3'd7));
        tick_requests.push_back(tick(1'b1, 1'b0, 7'h05, 7'h06, 6'h07, 3'd3));
        // 4 days of 24 plus 3 hours lands exactly on 99
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h59, 7'h59, 6'h03, 3'd5));
        tick_requests.push_back(tick(1'b1, 1'b0, 7'h00, 7'h00, 6'h00, 3'd1));
        // clamped from 167 down to the limit, then halts
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h59, 7'h59, 6'h23, 3'd7));
        tick_requests.push_back(tick(1'b1, 1'b0, 7'h00, 7'h00, 6'h00, 3'd1));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h59, 7'h59, 6'h02, 3'd5));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h59, 7'h58, 6'h03, 3'd5));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h59, 7'h59, 6'h03, 3'd0));
        tick_requests.push_back(tick(1'b0, 1'b1, 7'h00, 7'h00, 6'h00, 3'd1));
        tick_requests.push_back(tick(1'b0, 1'b0, 7'h2A, 7'h3B, 6'h2F, 3'd6));
        queue_random(180);
        wait_idle();

        foreach (limit_plan[i])
        begin
            set_hour_limit(limit_plan[i]);
            queue_random(185);
            wait_idle();
        end

        repeat (5) @(posedge clk);
        if (expected_ticks.size() != 0)
        begin
            $error("%0d results never arrived", expected_ticks.size());
            error_count++;
        end
        $display("Checked %0d results for %0d timer ticks over %0d hour-limit writes",
                 results_checked, requests_taken, limit_writes);
        $display("Saw %0d restarts and %0d automatic halts", restart_count, auto_halt_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/sset_pkg.sv
rtl/sset_tick_logic.sv
rtl/start_stop_elapsed_timer_display.sv
bench/start_stop_elapsed_timer_display_test.sv
